// File: sv/hs_pkg.sv
// Shared record type and sizing constants for the heap sort block.
package hs_pkg;

	localparam int unsigned HS_MAX_RECORDS = 64;
	localparam int unsigned HS_ID_W        = 16;
	localparam int unsigned HS_KEY_W       = 32;

	typedef struct packed {
		logic [HS_ID_W-1:0]  id;
		logic [HS_KEY_W-1:0] key;
	} rec_t;

endpackage

// File: sv/hs_mem.sv
// Record store: one write port and two registered read ports.
module hs_mem #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned AW    = 6
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  hs_pkg::rec_t  wdata,
	input  logic [AW-1:0] raddr_a,
	input  logic [AW-1:0] raddr_b,
	output hs_pkg::rec_t  rdata_a,
	output hs_pkg::rec_t  rdata_b
);
	import hs_pkg::*;

	rec_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

// File: sv/heap_sort_by_key_top.sv
// Top level of the heap sort block: load, heap build, extraction and emission sequencer.
//
// Usage. Records enter on the command channel: an item is taken at a rising edge where
// start is high and busy is low. Each item carries rec_id, sort_key (unsigned 16.16,
// compared as a plain 32-bit integer) and last_in. Up to MAX_RECORDS items are kept in
// the record store; further items of the same set are dropped and remembered.
// The item marked last_in ends the set: busy rises and the block sorts the set in place
// with a max-heap sort, then emits the records in ascending key order, one per cycle,
// each shown for exactly one cycle with strobe high. The final record carries last_out,
// and overflowed on it tells whether records of the set were dropped.
// Items load at one per cycle while busy is low. Each sift fetches its top, then reads
// and compares once per level descended and once more where the entry comes to rest.
// A set of n records needs n/2 build sifts and n-1 extraction sifts, run one after
// another, as the single read-modify-write path through the record store sets the pace.
// Busy falls in the cycle that shows the final record, so the next set may start
// loading at once.
// Reset clears the sequencer, the record count and the drop flag; the store is not
// cleared, as only entries written in the current set are ever read.
// The receiver cannot stall: results must be taken in the cycle they are shown.
module heap_sort_by_key_top #(
	parameter int unsigned MAX_RECORDS = hs_pkg::HS_MAX_RECORDS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [hs_pkg::HS_ID_W-1:0]  rec_id,
	input  logic [hs_pkg::HS_KEY_W-1:0] sort_key,
	input  logic                        last_in,
	output logic                        strobe,
	output logic [hs_pkg::HS_ID_W-1:0]  out_id,
	output logic [hs_pkg::HS_KEY_W-1:0] out_key,
	output logic                        last_out,
	output logic                        overflowed
);
	import hs_pkg::*;

	// Address width, count width (holds MAX_RECORDS itself) and child index width.
	localparam int unsigned AW  = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
	localparam int unsigned CW  = $clog2(MAX_RECORDS + 1);
	localparam int unsigned CHW = AW + 2;

	typedef enum logic [5:0] {
		ST_LOAD  = 6'b000001,
		ST_FETCH = 6'b000010,
		ST_TAKE  = 6'b000100,
		ST_READ  = 6'b001000,
		ST_CMP   = 6'b010000,
		ST_EMIT  = 6'b100000
	} state_t;

	state_t         state_q;
	logic [CW-1:0]  count_q;
	logic           drop_q;
	logic [CW-1:0]  n_q;
	logic [CW-1:0]  k_q;
	logic [CW-1:0]  len_q;
	logic [AW-1:0]  node_q;
	logic [AW-1:0]  idx_q;
	logic           build_q;
	rec_t           cur_q;
	logic           strobe_q;
	logic           last_q;
	logic           ovf_q;

	logic           accept;
	logic           room;
	logic [CW-1:0]  count_nxt;
	logic [CW-1:0]  k_dec;
	logic [CHW-1:0] lc;
	logic [CHW-1:0] rc;
	logic           lc_ok;
	logic           rc_ok;
	logic           take_l;
	logic           take_r;
	logic [HS_KEY_W-1:0] big_key;
	logic           final_emit;

	logic           mem_we;
	logic [AW-1:0]  mem_waddr;
	rec_t           mem_wdata;
	logic [AW-1:0]  raddr_a;
	logic [AW-1:0]  raddr_b;
	rec_t           rdata_a;
	rec_t           rdata_b;

	hs_mem #(
		.DEPTH(MAX_RECORDS),
		.AW   (AW)
	) u_mem (
		.clk    (clk),
		.we     (mem_we),
		.waddr  (mem_waddr),
		.wdata  (mem_wdata),
		.raddr_a(raddr_a),
		.raddr_b(raddr_b),
		.rdata_a(rdata_a),
		.rdata_b(rdata_b)
	);

	assign busy   = (state_q != ST_LOAD);
	assign accept = start && !busy;
	assign room   = (count_q < CW'(MAX_RECORDS));
	assign count_nxt = room ? count_q + CW'(1) : count_q;
	assign k_dec  = k_q - CW'(1);

	// Children of the node being sifted, and the decision between them. A child only
	// wins when strictly larger, which fixes how equal keys fall.
	assign lc      = {1'b0, node_q, 1'b1};
	assign rc      = lc + CHW'(1);
	assign lc_ok   = (lc < CHW'(len_q));
	assign rc_ok   = (rc < CHW'(len_q));
	assign take_l  = lc_ok && (rdata_a.key > cur_q.key);
	assign big_key = take_l ? rdata_a.key : cur_q.key;
	assign take_r  = rc_ok && (rdata_b.key > big_key);

	assign final_emit = (CW'(idx_q) == n_q - CW'(1));

	// Read addresses: the data come back in the following state.
	always_comb begin
		raddr_a = '0;
		raddr_b = '0;
		unique case (state_q)
			ST_FETCH: begin
				raddr_a = build_q ? k_dec[AW-1:0] : '0;
				raddr_b = k_dec[AW-1:0];
			end
			ST_READ: begin
				raddr_a = lc_ok ? lc[AW-1:0] : '0;
				raddr_b = rc_ok ? rc[AW-1:0] : '0;
			end
			ST_EMIT: begin
				raddr_a = idx_q;
			end
			ST_LOAD, ST_TAKE, ST_CMP: begin
				raddr_a = '0;
			end
			default: begin
				raddr_a = '0;
			end
		endcase
	end

	// Single write port: loading, the root swap of extraction, and sift write-back.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = cur_q;
		unique case (state_q)
			ST_LOAD: begin
				mem_we    = accept && room;
				mem_waddr = count_q[AW-1:0];
				mem_wdata = '{id: rec_id, key: sort_key};
			end
			ST_TAKE: begin
				mem_we    = !build_q;
				mem_waddr = k_dec[AW-1:0];
				mem_wdata = rdata_a;
			end
			ST_CMP: begin
				mem_we    = 1'b1;
				mem_waddr = node_q;
				if (take_r) begin
					mem_wdata = rdata_b;
				end else if (take_l) begin
					mem_wdata = rdata_a;
				end else begin
					mem_wdata = cur_q;
				end
			end
			ST_FETCH, ST_READ, ST_EMIT: begin
				mem_we = 1'b0;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_LOAD;
			count_q  <= '0;
			drop_q   <= 1'b0;
			n_q      <= '0;
			k_q      <= '0;
			len_q    <= '0;
			node_q   <= '0;
			idx_q    <= '0;
			build_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (accept) begin
						count_q <= count_nxt;
						if (!room) begin
							drop_q <= 1'b1;
						end
						if (last_in) begin
							n_q     <= count_nxt;
							idx_q   <= '0;
							// A set is never empty; a single record needs no sorting.
							if (count_nxt > CW'(1)) begin
								build_q <= 1'b1;
								k_q     <= count_nxt >> 1;
								state_q <= ST_FETCH;
							end else begin
								state_q <= ST_EMIT;
							end
						end
					end
				end
				ST_FETCH: begin
					state_q <= ST_TAKE;
				end
				ST_TAKE: begin
					// In extraction the old end entry sifts down from the root, and the
					// root has just been written to the end.
					if (build_q) begin
						node_q <= k_dec[AW-1:0];
						len_q  <= n_q;
					end else begin
						node_q <= '0;
						len_q  <= k_dec;
					end
					state_q <= ST_READ;
				end
				ST_READ: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (take_r) begin
						node_q  <= rc[AW-1:0];
						state_q <= ST_READ;
					end else if (take_l) begin
						node_q  <= lc[AW-1:0];
						state_q <= ST_READ;
					end else if (build_q) begin
						if (k_q == CW'(1)) begin
							build_q <= 1'b0;
							k_q     <= n_q;
						end else begin
							k_q <= k_dec;
						end
						state_q <= ST_FETCH;
					end else if (k_q == CW'(2)) begin
						state_q <= ST_EMIT;
					end else begin
						k_q     <= k_dec;
						state_q <= ST_FETCH;
					end
				end
				ST_EMIT: begin
					idx_q <= idx_q + AW'(1);
					if (final_emit) begin
						count_q <= '0;
						drop_q  <= 1'b0;
						state_q <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// Result flags line up with the record read during emission.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
			ovf_q    <= 1'b0;
		end else begin
			strobe_q <= (state_q == ST_EMIT);
			last_q   <= (state_q == ST_EMIT) && final_emit;
			ovf_q    <= (state_q == ST_EMIT) && final_emit && drop_q;
		end
	end

	// The sifting record is held here; it reaches the store only where it comes to rest.
	always_ff @(posedge clk) begin
		if (state_q == ST_TAKE) begin
			cur_q <= build_q ? rdata_a : rdata_b;
		end
	end

	assign strobe     = strobe_q;
	assign out_id     = rdata_a.id;
	assign out_key    = rdata_a.key;
	assign last_out   = last_q;
	assign overflowed = ovf_q;

endmodule

// File: sv/hs_check.sv
// Port-level checker for the heap sort block, bound to its top level.
module hs_check (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic last_in,
	input logic strobe,
	input logic last_out,
	input logic overflowed
);

	// A set ends with a sort, so the block is busy after the closing item.
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && last_in |=> busy)
		else $error("block not busy after the closing item");

	// Records of a set come out on consecutive cycles until the final one.
	a_emit_run: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last_out |=> strobe)
		else $error("gap inside the emission of a set");

	// The final record is followed by an idle cycle on the result side.
	a_emit_end: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last_out |=> !strobe)
		else $error("result shown after the final record");

	// Only the final record may report dropped records.
	a_ovf_final: assert property (@(posedge clk) disable iff (!arst_n)
		overflowed |-> strobe && last_out)
		else $error("overflow reported off the final record");

	// While records other than the final one are shown, no item is taken.
	a_emit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last_out |-> busy)
		else $error("block idle while a set is still being emitted");

endmodule

bind heap_sort_by_key_top hs_check u_hs_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.last_in   (last_in),
	.strobe    (strobe),
	.last_out  (last_out),
	.overflowed(overflowed)
);

// File: tb/tb_heap_sort_pkg.sv
`timescale 1ns / 1ps
// Scoreboard class that predicts and checks the sorted output of the heap sort block.
package tb_heap_sort_pkg;
	import hs_pkg::*;

	typedef struct {
		rec_t rec;
		bit   fin;
		bit   ovf;
	} sorted_rec_t;

	class heap_sort_board;
		rec_t        slots[HS_MAX_RECORDS];
		int unsigned held;
		bit          dropped;
		sorted_rec_t sorted_due[$];
		int unsigned failures;

		function new();
			held = 0;
			dropped = 0;
			failures = 0;
		endfunction

		function void swap_slots(int unsigned a, int unsigned b);
			rec_t t;
			t = slots[a];
			slots[a] = slots[b];
			slots[b] = t;
		endfunction

		// Push the entry at top down a max-heap of len entries.
		function void sift(int unsigned len, int unsigned top);
			int unsigned node, big, lc, rc;
			node = top;
			while (1) begin
				big = node;
				lc = 2 * node + 1;
				rc = 2 * node + 2;
				if (lc < len && slots[lc].key > slots[big].key)
					big = lc;
				if (rc < len && slots[rc].key > slots[big].key)
					big = rc;
				if (big == node)
					return;
				swap_slots(node, big);
				node = big;
			end
		endfunction

		function void note_record(logic [HS_ID_W-1:0] id, logic [HS_KEY_W-1:0] key, logic fin);
			sorted_rec_t e;
			int unsigned k;
			if (held < HS_MAX_RECORDS) begin
				slots[held].id = id;
				slots[held].key = key;
				held++;
			end else begin
				dropped = 1'b1;
			end
			if (!fin)
				return;
			// Bottom-up heap build, then repeated extraction of the root to the end.
			for (k = held / 2; k > 0; k--)
				sift(held, k - 1);
			for (k = held; k > 0; k--) begin
				swap_slots(0, k - 1);
				sift(k - 1, 0);
			end
			for (k = 0; k < held; k++) begin
				e.rec = slots[k];
				e.fin = (k + 1 == held);
				e.ovf = e.fin && dropped;
				sorted_due.insert(sorted_due.size(), e);
			end
			held = 0;
			dropped = 1'b0;
		endfunction

		function int unsigned pending();
			return sorted_due.size();
		endfunction

		function void check_emitted(logic [HS_ID_W-1:0] id, logic [HS_KEY_W-1:0] key,
				logic fin, logic ovf);
			sorted_rec_t e;
			if (sorted_due.size() == 0) begin
				$display("%0t: result with none expected: id %h key %h last %b overflow %b",
					$time, id, key, fin, ovf);
				failures++;
				return;
			end
			e = sorted_due.pop_front();
			if (id !== e.rec.id) begin
				$display("%0t: out_id expected %h, actual %h", $time, e.rec.id, id);
				failures++;
			end
			if (key !== e.rec.key) begin
				$display("%0t: out_key expected %h, actual %h", $time, e.rec.key, key);
				failures++;
			end
			if (fin !== e.fin) begin
				$display("%0t: last_out expected %b, actual %b", $time, e.fin, fin);
				failures++;
			end
			if (ovf !== e.ovf) begin
				$display("%0t: overflowed expected %b, actual %b", $time, e.ovf, ovf);
				failures++;
			end
		endfunction
	endclass

endpackage

// File: tb/tb_heap_sort_by_key_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the heap sort block: record sets in, sorted records checked out.
module tb_heap_sort_by_key_top;
	import hs_pkg::*;
	import tb_heap_sort_pkg::*;

	// Key flavours for a set; tied keys repeat often, so that the order in which the heap sort
	// leaves ties is exercised thoroughly, and narrow keys have only four integer parts.
	typedef enum int unsigned {
		KEYS_WIDE,
		KEYS_TIED,
		KEYS_EDGE,
		KEYS_NARROW
	} key_mix_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	logic [HS_ID_W-1:0]  rec_id = '0;
	logic [HS_KEY_W-1:0] sort_key = '0;
	logic                last_in = 1'b0;
	logic                strobe;
	logic [HS_ID_W-1:0]  out_id;
	logic [HS_KEY_W-1:0] out_key;
	logic                last_out;
	logic                overflowed;

	heap_sort_board board = new();
	int unsigned    items_sent = 0;
	bit             idle_ok = 1'b1;
	bit             paused_mid = 1'b0;

	heap_sort_by_key_top DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.rec_id     (rec_id),
		.sort_key   (sort_key),
		.last_in    (last_in),
		.strobe     (strobe),
		.out_id     (out_id),
		.out_key    (out_key),
		.last_out   (last_out),
		.overflowed (overflowed)
	);

	always #5 clk = ~clk;

	// An item is taken at a rising edge with start high and busy low. The values read here
	// are those from before the edge, since the block updates its outputs non-blocking.
	always @(posedge clk) begin
		if (arst_n && start && !busy)
			board.note_record(rec_id, sort_key, last_in);
	end

	// Every strobed result is compared with the oldest sorted record still awaited.
	always @(posedge clk) begin
		if (arst_n && strobe)
			board.check_emitted(out_id, out_key, last_out, overflowed);
	end

	function automatic logic [HS_KEY_W-1:0] pick_key(key_mix_t mix);
		logic [HS_KEY_W-1:0] k;
		case (mix)
			KEYS_TIED:   k = $urandom_range(0, 7);
			KEYS_EDGE: begin
				case ($urandom_range(0, 3))
					0:       k = 32'h0000_0000;
					1:       k = 32'hFFFF_FFFF;
					2:       k = 32'h8000_0000;
					default: k = 32'h0001_0000;
				endcase
			end
			KEYS_NARROW: k = {16'($urandom_range(0, 3)), 16'($urandom)};
			default:     k = $urandom;
		endcase
		return k;
	endfunction

	// Offers one item and holds it until the block takes it. Start is left high afterwards,
	// so that back-to-back items keep it high without a dip; an idle burst, when one is
	// drawn, lowers it and puts noise on the fields before the item is shown.
	task automatic send_record(input logic [HS_ID_W-1:0] id, input logic [HS_KEY_W-1:0] key,
			input logic fin);
		if (idle_ok && $urandom_range(0, 4) == 0) begin
			start = 1'b0;
			rec_id = 16'($urandom);
			sort_key = $urandom;
			last_in = 1'($urandom_range(0, 1));
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
		start = 1'b1;
		rec_id = id;
		sort_key = key;
		last_in = fin;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic send_set(input int unsigned n, input key_mix_t mix);
		int unsigned i;
		for (i = 0; i < n; i++)
			send_record(16'($urandom), pick_key(mix), i + 1 == n);
	endtask

	// Holds the sender back until every sorted record awaited has been emitted.
	task automatic settle();
		start = 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	initial begin
		int unsigned n, pick;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Single-record sets at both ends of the key and id ranges.
		send_record(16'hFFFF, 32'hFFFF_FFFF, 1'b1);
		send_record(16'h0000, 32'h0000_0000, 1'b1);
		// A mixed set: repeated extremes, one integer step and the largest key below 8000_0000.
		send_record(16'h0001, 32'hFFFF_FFFF, 1'b0);
		send_record(16'h0002, 32'h0000_0000, 1'b0);
		send_record(16'h0003, 32'h0001_0000, 1'b0);
		send_record(16'h0004, 32'hFFFF_FFFF, 1'b0);
		send_record(16'h0005, 32'h0000_0000, 1'b0);
		send_record(16'h0006, 32'h7FFF_FFFF, 1'b1);
		// All keys equal: the output order is purely that of the heap's tie handling.
		send_record(16'h00A0, 32'h1234_5678, 1'b0);
		send_record(16'h00A1, 32'h1234_5678, 1'b0);
		send_record(16'h00A2, 32'h1234_5678, 1'b0);
		send_record(16'h00A3, 32'h1234_5678, 1'b0);
		send_record(16'h00A4, 32'h1234_5678, 1'b1);
		// Already descending, then already ascending.
		send_record(16'h0B00, 32'h0004_0000, 1'b0);
		send_record(16'h0B01, 32'h0003_0000, 1'b0);
		send_record(16'h0B02, 32'h0002_0000, 1'b0);
		send_record(16'h0B03, 32'h0001_0000, 1'b1);
		send_record(16'h0C00, 32'h0000_0001, 1'b0);
		send_record(16'h0C01, 32'h0000_0002, 1'b0);
		send_record(16'h0C02, 32'h0000_0003, 1'b0);
		send_record(16'h0C03, 32'h0000_0004, 1'b1);

		// Let the block drain completely once, then fill the store exactly, and then
		// overrun it so that the record marked last is itself dropped.
		settle();
		send_set(64, KEYS_WIDE);
		send_set(66, KEYS_TIED);

		// Random sets: mostly small, some medium, a few full or overrunning the store.
		// Idling stops for the closing stretch of the run.
		while (items_sent < 470) begin
			if (items_sent >= 400)
				idle_ok = 1'b0;
			if (!paused_mid && items_sent >= 250) begin
				settle();
				paused_mid = 1'b1;
			end
			pick = $urandom_range(0, 19);
			if (pick == 0)
				n = 64;
			else if (pick == 1)
				n = $urandom_range(65, 72);
			else if (pick <= 4)
				n = $urandom_range(13, 63);
			else
				n = $urandom_range(1, 12);
			send_set(n, key_mix_t'($urandom_range(0, 3)));
		end

		start = 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (32) @(posedge clk);
		if (board.failures == 0)
			$display("heap_sort_by_key_top test passed");
		else
			$display("heap_sort_by_key_top test failed");
		$finish;
	end

	// Guard against a hang: the slowest correct run is well under a tenth of this.
	initial begin
		#5_000_000;
		$display("heap_sort_by_key_top test failed");
		$finish;
	end

endmodule

// File: files.f
sv/hs_pkg.sv
sv/hs_mem.sv
sv/heap_sort_by_key_top.sv
sv/hs_check.sv
tb/tb_heap_sort_pkg.sv
tb/tb_heap_sort_by_key_top.sv
